// ===== hw/rtl/rbts_pkg.sv =====
// Shared types and constants of the rule bytecode transition select block.
package rbts_pkg;

	localparam int unsigned CODE_DET     = 32;
	localparam int unsigned CODE_CNT     = 64;
	localparam int unsigned CODE_CNT_END = 76;
	localparam int unsigned CODE_LIT     = 128;
	localparam int unsigned NODE_SLOTS   = 128;
	localparam int unsigned DIV_STEPS    = 32;

	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_EQ   = 4'd1;
	localparam logic [3:0] OP_NE   = 4'd2;
	localparam logic [3:0] OP_LT   = 4'd3;
	localparam logic [3:0] OP_LE   = 4'd4;
	localparam logic [3:0] OP_GT   = 4'd5;
	localparam logic [3:0] OP_GE   = 4'd6;
	localparam logic [3:0] OP_ADD  = 4'd7;
	localparam logic [3:0] OP_SUB  = 4'd8;
	localparam logic [3:0] OP_MUL  = 4'd9;
	localparam logic [3:0] OP_DIV  = 4'd10;
	localparam logic [3:0] OP_MOD  = 4'd11;
	localparam logic [3:0] OP_AND  = 4'd12;
	localparam logic [3:0] OP_OR   = 4'd13;

	localparam logic [1:0] REG_OP_LIMIT  = 2'd0;
	localparam logic [1:0] REG_TRANS_USE = 2'd1;
	localparam logic [1:0] REG_ANY_STATE = 2'd2;

	typedef enum logic [2:0] {
		CMD_PHASE,
		CMD_DET,
		CMD_CNT,
		CMD_OP,
		CMD_RULE,
		CMD_TRANS,
		CMD_EVAL,
		CMD_SEL
	} cmd_t;

	typedef struct packed {
		logic [3:0] opr;
		logic [7:0] a;
		logic [7:0] b;
	} op_entry_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic take;
		logic eval_init;
		logic opa;
		logic opb;
		logic opc;
		logic alu_wb;
		logic div_start;
		logic div_wb;
		logic eval_end;
		logic sel_chk;
		logic sel_adv;
		logic sel_upd;
		logic out_load;
	} ctl_t;

	// Datapath to controller status.
	typedef struct packed {
		cmd_t kind;
		logic fetch_ok;
		logic op_none;
		logic div_op;
		logic div_done;
		logic sel_more;
		logic sel_match;
	} sts_t;

endpackage

// ===== hw/rtl/rbts_ram.sv =====
// Generic single write port RAM with one registered read port.
module rbts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/rbts_div.sv =====
// Restoring divider producing one quotient bit per cycle.
module rbts_div
	import rbts_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= 6'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 32'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/rbts_dp.sv =====
// Datapath: stores, operand decode, ALU, divider and select bookkeeping.
module rbts_dp
	import rbts_pkg::*;
#(
	parameter int PHASE_COUNT      = 32,
	parameter int DETECTOR_COUNT   = 32,
	parameter int COUNTER_COUNT    = 12,
	parameter int POOL_DEPTH       = 256,
	parameter int RULE_COUNT       = 32,
	parameter int TRANSITION_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	input  cmd_t        in_cmd,
	input  logic [7:0]  in_index,
	input  logic [31:0] in_value,
	input  logic [3:0]  in_op_code,
	input  logic [7:0]  in_operand_a,
	input  logic [7:0]  in_operand_b,
	input  logic [7:0]  in_rule_start,
	input  logic [7:0]  in_from_state,
	input  logic [7:0]  in_priority,
	input  logic [4:0]  in_rule_index,
	input  logic [7:0]  in_current_state,
	input  logic [8:0]  op_limit,
	input  logic [5:0]  trans_use,
	input  logic [7:0]  any_state,
	output logic [27:0] out_data
);

	localparam int PW = $clog2(POOL_DEPTH > 1 ? POOL_DEPTH : 2);
	localparam int RW = $clog2(RULE_COUNT > 1 ? RULE_COUNT : 2);
	localparam int TW = $clog2(TRANSITION_COUNT > 1 ? TRANSITION_COUNT : 2);
	localparam int VW = $clog2(CODE_CNT_END);
	localparam int NW = $clog2(NODE_SLOTS);

	// Item registers.
	cmd_t        cmd_q;
	logic [7:0]  rule_num_q;
	logic [7:0]  cur_q;

	// Evaluation registers.
	logic [8:0]  pc_q;
	logic [8:0]  done_q;
	logic [31:0] last_q;
	op_entry_t   op_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        ok_q;

	// Select registers.
	logic [7:0]  ti_q;
	logic [7:0]  tn_q;
	logic [7:0]  tfrom_q;
	logic [7:0]  tprio_q;
	logic [4:0]  trule_q;
	logic        found_q;
	logic [4:0]  bidx_q;
	logic [7:0]  bprio_q;
	logic [4:0]  brule_q;
	logic [7:0]  bfrom_q;
	logic [27:0] out_q;

	// Valid bits of the zero-reset stores, and their registered read copies.
	logic [CODE_CNT_END-1:0] vval_q;
	logic [POOL_DEPTH-1:0]   pval_q;
	logic [RULE_COUNT-1:0]   rval_q;
	logic                    vrd_q;
	logic                    prd_q;
	logic                    rrd_q;

	// Store ports.
	logic          v_we;
	logic [VW-1:0] v_waddr;
	logic [VW-1:0] v_raddr;
	logic [31:0]   v_rdata;
	logic          p_we;
	logic [19:0]   p_rdata;
	logic          r_we;
	logic [7:0]    r_rdata;
	logic          t_we;
	logic [20:0]   t_rdata;
	logic          n_we;
	logic [31:0]   n_rdata;
	logic [7:0]    rd_code;

	logic        is_write;
	logic        in_idx_ok;
	op_entry_t   entry;
	logic [31:0] opnd;
	logic [31:0] alu_res;
	logic [31:0] wb_res;
	logic        wb;
	logic        div_done;
	logic [31:0] div_quo;
	logic [31:0] div_rem;
	logic [7:0]  tfrom_rd;
	logic [7:0]  tn_next;

	function automatic logic [31:0] alu(input logic [3:0] opr, input logic [31:0] a,
			input logic [31:0] b);
		logic [31:0] r;
		begin
			case (opr)
				OP_EQ:   r = {31'd0, a == b};
				OP_NE:   r = {31'd0, a != b};
				OP_LT:   r = {31'd0, a < b};
				OP_LE:   r = {31'd0, a <= b};
				OP_GT:   r = {31'd0, a > b};
				OP_GE:   r = {31'd0, a >= b};
				OP_ADD:  r = a + b;
				OP_SUB:  r = (a > b) ? a - b : 32'd0;
				OP_MUL:  r = a * b;
				OP_AND:  r = {31'd0, (a != 32'd0) && (b != 32'd0)};
				OP_OR:   r = {31'd0, (a != 32'd0) || (b != 32'd0)};
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

	// Write decode for the command items that only fill stores.
	always_comb begin
		v_we      = 1'b0;
		v_waddr   = '0;
		p_we      = 1'b0;
		r_we      = 1'b0;
		t_we      = 1'b0;
		is_write  = 1'b1;
		in_idx_ok = 1'b0;
		case (in_cmd)
			CMD_PHASE: begin
				in_idx_ok = {1'b0, in_index} < 9'(PHASE_COUNT);
				v_we      = ctl.take && in_idx_ok;
				v_waddr   = VW'(in_index[4:0]);
			end
			CMD_DET: begin
				in_idx_ok = {1'b0, in_index} < 9'(DETECTOR_COUNT);
				v_we      = ctl.take && in_idx_ok;
				v_waddr   = VW'(CODE_DET) + VW'(in_index[4:0]);
			end
			CMD_CNT: begin
				in_idx_ok = {1'b0, in_index} < 9'(COUNTER_COUNT);
				v_we      = ctl.take && in_idx_ok;
				v_waddr   = VW'(CODE_CNT) + VW'(in_index[3:0]);
			end
			CMD_OP: begin
				in_idx_ok = {1'b0, in_index} < 9'(POOL_DEPTH);
				p_we      = ctl.take && in_idx_ok;
			end
			CMD_RULE: begin
				in_idx_ok = {1'b0, in_index} < 9'(RULE_COUNT);
				r_we      = ctl.take && in_idx_ok;
			end
			CMD_TRANS: begin
				in_idx_ok = {1'b0, in_index} < 9'(TRANSITION_COUNT);
				t_we      = ctl.take && in_idx_ok;
			end
			default: is_write = 1'b0;
		endcase
	end

	// Pool entries that were never written read as the none operator.
	assign entry   = prd_q ? op_entry_t'(p_rdata) : '0;
	assign rd_code = ctl.opa ? entry.a : op_q.b;
	assign v_raddr = (rd_code < 8'(CODE_CNT_END)) ? rd_code[VW-1:0] : '0;

	// Operand decode; the code being decoded is the one read in the cycle before.
	always_comb begin
		logic [7:0] code;
		code = ctl.opb ? op_q.a : op_q.b;
		opnd = 32'd0;
		if (code[7]) begin
			opnd = {25'd0, code[6:0]};
		end else if (code < 8'(CODE_CNT_END)) begin
			opnd = vrd_q ? v_rdata : 32'd0;
		end else if ({1'b0, code} < done_q) begin
			opnd = n_rdata;
		end
	end

	assign alu_res = alu(op_q.opr, a_q, b_q);
	assign wb      = ctl.alu_wb || ctl.div_wb;
	assign wb_res  = ctl.div_wb ? ((op_q.opr == OP_DIV) ? div_quo : div_rem) : alu_res;
	assign n_we    = wb && (done_q < 9'(NODE_SLOTS));
	assign tfrom_rd = t_rdata[7:0];
	assign tn_next = ({2'b0, trans_use} > 8'(TRANSITION_COUNT)) ?
		8'(TRANSITION_COUNT) : {2'b0, trans_use};

	rbts_ram #(.WIDTH(32), .DEPTH(CODE_CNT_END)) u_val_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(in_value),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	rbts_ram #(.WIDTH(20), .DEPTH(POOL_DEPTH)) u_pool_ram (
		.clk(clk), .we(p_we), .waddr(in_index[PW-1:0]),
		.wdata({in_op_code, in_operand_a, in_operand_b}),
		.raddr(pc_q[PW-1:0]), .rdata(p_rdata)
	);

	rbts_ram #(.WIDTH(8), .DEPTH(RULE_COUNT)) u_rule_ram (
		.clk(clk), .we(r_we), .waddr(in_index[RW-1:0]), .wdata(in_rule_start),
		.raddr(rule_num_q[RW-1:0]), .rdata(r_rdata)
	);

	rbts_ram #(.WIDTH(21), .DEPTH(TRANSITION_COUNT)) u_trans_ram (
		.clk(clk), .we(t_we), .waddr(in_index[TW-1:0]),
		.wdata({in_rule_index, in_priority, in_from_state}),
		.raddr(ti_q[TW-1:0]), .rdata(t_rdata)
	);

	rbts_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_node_ram (
		.clk(clk), .we(n_we), .waddr(done_q[NW-1:0]), .wdata(wb_res),
		.raddr(rd_code[NW-1:0]), .rdata(n_rdata)
	);

	rbts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(ctl.div_start),
		.dividend(a_q), .divisor(b_q), .done(div_done), .quo(div_quo), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vval_q <= '0;
			pval_q <= '0;
			rval_q <= '0;
			cmd_q  <= CMD_PHASE;
		end else begin
			if (v_we) begin
				vval_q[v_waddr] <= 1'b1;
			end
			if (p_we) begin
				pval_q[in_index[PW-1:0]] <= 1'b1;
			end
			if (r_we) begin
				rval_q[in_index[RW-1:0]] <= 1'b1;
			end
			if (ctl.take && !is_write) begin
				cmd_q <= in_cmd;
			end
		end
	end

	always_ff @(posedge clk) begin
		vrd_q <= vval_q[v_raddr];
		prd_q <= pval_q[pc_q[PW-1:0]];
		rrd_q <= rval_q[rule_num_q[RW-1:0]];

		if (ctl.take) begin
			rule_num_q <= in_index;
			cur_q      <= in_current_state;
			ti_q       <= '0;
			tn_q       <= tn_next;
			found_q    <= 1'b0;
			bidx_q     <= '0;
			bprio_q    <= '0;
			brule_q    <= '0;
			bfrom_q    <= '0;
			ok_q       <= 1'b0;
		end
		if (ctl.eval_init) begin
			pc_q   <= rrd_q ? {1'b0, r_rdata} : 9'd0;
			done_q <= '0;
			last_q <= '0;
		end
		if (ctl.opa) begin
			op_q <= entry;
		end
		if (ctl.opb) begin
			a_q <= opnd;
		end
		if (ctl.opc) begin
			b_q <= opnd;
		end
		if (wb) begin
			last_q <= wb_res;
			done_q <= done_q + 9'd1;
			pc_q   <= pc_q + 9'd1;
		end
		if (ctl.eval_end) begin
			ok_q <= (done_q != 9'd0) && (last_q != 32'd0);
		end
		if (ctl.sel_chk) begin
			tfrom_q    <= tfrom_rd;
			tprio_q    <= t_rdata[15:8];
			trule_q    <= t_rdata[20:16];
			rule_num_q <= {3'd0, t_rdata[20:16]};
		end
		if (ctl.sel_upd && ok_q && (!found_q || (tprio_q > bprio_q))) begin
			found_q <= 1'b1;
			bidx_q  <= ti_q[4:0];
			bprio_q <= tprio_q;
			brule_q <= trule_q;
			bfrom_q <= tfrom_q;
		end
		if (ctl.sel_adv || ctl.sel_upd) begin
			ti_q <= ti_q + 8'd1;
		end
		if (ctl.out_load) begin
			out_q <= {bfrom_q, brule_q, bprio_q, bidx_q, found_q,
				(cmd_q == CMD_EVAL) && ok_q};
		end
	end

	// A rule number past the table takes the empty path: start then straight to the end.
	always_comb begin
		sts.kind      = cmd_q;
		sts.fetch_ok  = (done_q < op_limit) && (pc_q < 9'(POOL_DEPTH)) &&
			({1'b0, rule_num_q} < 9'(RULE_COUNT));
		sts.op_none   = entry.opr == OP_NONE;
		sts.div_op    = ((op_q.opr == OP_DIV) || (op_q.opr == OP_MOD)) && (b_q != 32'd0);
		sts.div_done  = div_done;
		sts.sel_more  = ti_q < tn_q;
		sts.sel_match = (tfrom_rd == any_state) || (tfrom_rd == cur_q);
	end

	assign out_data = out_q;

endmodule

// ===== hw/rtl/rbts_ctrl.sv =====
// Controller state machine sequencing evaluate and select commands.
module rbts_ctrl
	import rbts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  cmd_t in_cmd,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output ctl_t ctl
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RULE,
		S_START,
		S_FETCH,
		S_OPA,
		S_OPB,
		S_OPC,
		S_ALU,
		S_DIV,
		S_EEND,
		S_TREAD,
		S_TCHECK,
		S_TUPD,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		ctl           = '0;
		ctl.take      = in_valid && (state_q == S_IDLE);
		ctl.eval_init = state_q == S_START;
		ctl.opa       = state_q == S_OPA;
		ctl.opb       = state_q == S_OPB;
		ctl.opc       = state_q == S_OPC;
		ctl.alu_wb    = (state_q == S_ALU) && !sts.div_op;
		ctl.div_start = (state_q == S_ALU) && sts.div_op;
		ctl.div_wb    = (state_q == S_DIV) && sts.div_done;
		ctl.eval_end  = state_q == S_EEND;
		ctl.sel_chk   = state_q == S_TCHECK;
		ctl.sel_adv   = (state_q == S_TCHECK) && !sts.sel_match;
		ctl.sel_upd   = state_q == S_TUPD;
		ctl.out_load  = (state_q == S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new result replaces the one taken in the same cycle.
			if ((state_q == S_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (in_cmd == CMD_EVAL) begin
							state_q <= S_RULE;
						end else if (in_cmd == CMD_SEL) begin
							state_q <= S_TREAD;
						end
					end
				end
				S_RULE:  state_q <= S_START;
				S_START: state_q <= S_FETCH;
				S_FETCH: state_q <= sts.fetch_ok ? S_OPA : S_EEND;
				S_OPA:   state_q <= sts.op_none ? S_EEND : S_OPB;
				S_OPB:   state_q <= S_OPC;
				S_OPC:   state_q <= S_ALU;
				S_ALU:   state_q <= sts.div_op ? S_DIV : S_FETCH;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_FETCH;
					end
				end
				S_EEND:  state_q <= (sts.kind == CMD_SEL) ? S_TUPD : S_FINISH;
				S_TREAD: state_q <= sts.sel_more ? S_TCHECK : S_FINISH;
				S_TCHECK: state_q <= sts.sel_match ? S_RULE : S_TREAD;
				S_TUPD:  state_q <= S_TREAD;
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/rule_bytecode_transition_select_core.sv =====
// Top level of the rule bytecode evaluator and transition selector.
// This block keeps phase times, detector demands, counters, an operation pool, rule start
// indices and a transition table, all filled by write requests on the input stream; each
// write request is taken while the block is idle and returns nothing. An evaluate request
// runs one rule's bytecode and returns one result request with rule_true; a select request
// scans the first min(transitions_in_use, TRANSITION_COUNT) table entries and returns the
// first entry of highest priority whose from-state matches and whose rule holds. The
// controller walks the operation pool one entry at a time through memories with one write
// port and one registered read port, and runs a bit-serial divider for each divide or
// modulo by a nonzero value. A select reads each scanned entry in turn and runs one
// evaluation per entry whose from-state matches. One request is in work at a time; a
// finished result waits in the output register while the block takes new write requests,
// and the next evaluate or select starts at once but holds its result until the previous
// one has been taken. Configuration registers sit on the APB port at byte addresses 0
// (op_limit), 4 (transitions_in_use) and 8 (any_state_code) and are to be written only
// while the block is idle.
module rule_bytecode_transition_select_core
	import rbts_pkg::*;
#(
	parameter int PHASE_COUNT      = 32,
	parameter int DETECTOR_COUNT   = 32,
	parameter int COUNTER_COUNT    = 12,
	parameter int POOL_DEPTH       = 256,
	parameter int RULE_COUNT       = 32,
	parameter int TRANSITION_COUNT = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// index[7:0], value[39:8], op_code[43:40], operand_a[51:44], operand_b[59:52],
	// rule_start[67:60], from_state[75:68], priority_req[83:76], rule_index[88:84],
	// current_state[96:89], zero fill above.
	input  logic [103:0] s_tdata,
	// cmd[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rule_true[0], found[1], best_index[6:2], best_priority[14:7], best_rule[19:15],
	// best_from[27:20], zero fill above.
	output logic [31:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic [8:0]  op_limit_q;
	logic [5:0]  trans_use_q;
	logic [7:0]  any_state_q;
	logic        cfg_wr;
	logic [27:0] out_data;
	cmd_t        in_cmd;
	ctl_t        ctl;
	sts_t        sts;

	assign in_cmd = cmd_t'(s_tuser);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers; writes past the register list fall through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_limit_q  <= 9'd256;
			trans_use_q <= 6'd0;
			any_state_q <= 8'd255;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_OP_LIMIT:  op_limit_q  <= pwdata[8:0];
				REG_TRANS_USE: trans_use_q <= pwdata[5:0];
				REG_ANY_STATE: any_state_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_OP_LIMIT:  prdata = {23'd0, op_limit_q};
			REG_TRANS_USE: prdata = {26'd0, trans_use_q};
			REG_ANY_STATE: prdata = {24'd0, any_state_q};
			default:       prdata = 32'd0;
		endcase
	end

	// The controller sequences one request at a time; the datapath owns all stores, the configuration registers sit here.
	rbts_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_cmd(in_cmd), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.sts(sts), .ctl(ctl)
	);

	rbts_dp #(
		.PHASE_COUNT(PHASE_COUNT), .DETECTOR_COUNT(DETECTOR_COUNT),
		.COUNTER_COUNT(COUNTER_COUNT), .POOL_DEPTH(POOL_DEPTH),
		.RULE_COUNT(RULE_COUNT), .TRANSITION_COUNT(TRANSITION_COUNT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.in_cmd(in_cmd),
		.in_index(s_tdata[7:0]),
		.in_value(s_tdata[39:8]),
		.in_op_code(s_tdata[43:40]),
		.in_operand_a(s_tdata[51:44]),
		.in_operand_b(s_tdata[59:52]),
		.in_rule_start(s_tdata[67:60]),
		.in_from_state(s_tdata[75:68]),
		.in_priority(s_tdata[83:76]),
		.in_rule_index(s_tdata[88:84]),
		.in_current_state(s_tdata[96:89]),
		.op_limit(op_limit_q), .trans_use(trans_use_q), .any_state(any_state_q),
		.out_data(out_data)
	);

	assign m_tdata = {4'd0, out_data};

endmodule

// ===== hw/rtl/rbts_checker.sv =====
// Port-level checks of the rule bytecode transition select block and their binding.
module rbts_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        pready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[1] |-> m_tdata[27:2] == 26'd0)
		else $error("best fields set without a found transition");

	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("rule_true and found both set");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:28] == 4'd0 && pready)
		else $error("result padding not zero or port not ready");

endmodule

bind rule_bytecode_transition_select_core rbts_props u_rbts_props (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .pready(pready)
);

// ===== bench/rbts_checker.sv =====
// Checker for the rule bytecode transition select block: prediction, result queue, compare.
module rbts_checker
	import rbts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [103:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [31:0]  m_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           mismatches,
	output int           pending,
	output int           results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_PHASE = 32;
	localparam int N_DET   = 32;
	localparam int N_CNT   = 12;
	localparam int N_POOL  = 256;
	localparam int N_RULE  = 32;
	localparam int N_TRANS = 32;

	// Highest field first, so that rule_true lands in bit 0 as on the port.
	typedef struct packed {
		logic [7:0] from_st;
		logic [4:0] rule;
		logic [7:0] prio;
		logic [4:0] idx;
		logic       found;
		logic       rule_true;
	} verdict_t;

	logic [31:0] phase_time [N_PHASE];
	logic [31:0] det_demand [N_DET];
	logic [31:0] cnt_value [N_CNT];
	op_entry_t   pool [N_POOL];
	logic [7:0]  rule_base [N_RULE];
	logic [7:0]  tr_from [N_TRANS];
	logic [7:0]  tr_prio [N_TRANS];
	logic [4:0]  tr_rule [N_TRANS];
	logic [31:0] node_val [NODE_SLOTS];
	int unsigned op_cap;
	int unsigned scan_len;
	logic [7:0]  wildcard_state;
	verdict_t    verdict_q [$];

	function automatic logic [31:0] operand(logic [7:0] code, int unsigned done);
		if (code >= CODE_LIT) return 32'(code - CODE_LIT);
		if (code >= CODE_CNT && code < CODE_CNT_END) return cnt_value[code - CODE_CNT];
		if (code >= CODE_DET && code < CODE_CNT) return det_demand[code - CODE_DET];
		if (code < CODE_DET) return phase_time[code];
		// Node references only see nodes already computed in this evaluation.
		if (code < done) return node_val[code];
		return 32'd0;
	endfunction

	function automatic logic [31:0] alu(logic [3:0] opr, logic [31:0] a, logic [31:0] b);
		case (opr)
			OP_EQ:  return 32'(a == b);
			OP_NE:  return 32'(a != b);
			OP_LT:  return 32'(a < b);
			OP_LE:  return 32'(a <= b);
			OP_GT:  return 32'(a > b);
			OP_GE:  return 32'(a >= b);
			OP_ADD: return a + b;
			OP_SUB: return (a > b) ? a - b : 32'd0;
			OP_MUL: return a * b;
			OP_DIV: return (b != 0) ? a / b : 32'd0;
			OP_MOD: return (b != 0) ? a % b : 32'd0;
			OP_AND: return 32'(a != 0 && b != 0);
			OP_OR:  return 32'(a != 0 || b != 0);
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic rule_holds(int unsigned r);
		int unsigned base, i, done;
		logic [31:0] last, a, b;
		op_entry_t e;
		if (r >= N_RULE) return 1'b0;
		base = rule_base[r];
		done = 0;
		last = 0;
		for (i = 0; i < op_cap && base + i < N_POOL; i++) begin
			e = pool[base + i];
			if (e.opr == OP_NONE) break;
			a = operand(e.a, done);
			b = operand(e.b, done);
			last = alu(e.opr, a, b);
			if (done < NODE_SLOTS) node_val[done] = last;
			done++;
		end
		return done != 0 && last != 0;
	endfunction

	function automatic verdict_t pick_transition(logic [7:0] cur);
		verdict_t v;
		int unsigned n, i;
		v = '0;
		n = (scan_len > N_TRANS) ? N_TRANS : scan_len;
		for (i = 0; i < n; i++) begin
			if (tr_from[i] != wildcard_state && tr_from[i] != cur) continue;
			if (!rule_holds(tr_rule[i])) continue;
			if (!v.found || tr_prio[i] > v.prio) begin
				v.found = 1'b1;
				v.idx = 5'(i);
				v.prio = tr_prio[i];
				v.rule = tr_rule[i];
				v.from_st = tr_from[i];
			end
		end
		return v;
	endfunction

	function automatic void compare(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cmd_t        cmd;
		logic [7:0]  idx;
		logic [31:0] value;
		verdict_t    want, got;
		if (!arst_n) begin
			foreach (phase_time[i]) phase_time[i] = '0;
			foreach (det_demand[i]) det_demand[i] = '0;
			foreach (cnt_value[i]) cnt_value[i] = '0;
			foreach (pool[i]) pool[i] = '0;
			foreach (rule_base[i]) rule_base[i] = '0;
			op_cap = 256;
			scan_len = 0;
			wildcard_state = 8'd255;
			verdict_q.delete();
			mismatches = 0;
			results = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results++;
				got = verdict_t'(m_tdata[27:0]);
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
					mismatches++;
				end else begin
					want = verdict_q.pop_front();
					compare("rule_true", want.rule_true, got.rule_true);
					compare("found", want.found, got.found);
					compare("best_index", want.idx, got.idx);
					compare("best_priority", want.prio, got.prio);
					compare("best_rule", want.rule, got.rule);
					compare("best_from", want.from_st, got.from_st);
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_OP_LIMIT:  op_cap = pwdata[8:0];
					REG_TRANS_USE: scan_len = pwdata[5:0];
					REG_ANY_STATE: wildcard_state = pwdata[7:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				cmd = cmd_t'(s_tuser);
				idx = s_tdata[7:0];
				value = s_tdata[39:8];
				case (cmd)
					CMD_PHASE: if (idx < N_PHASE) phase_time[idx] = value;
					CMD_DET:   if (idx < N_DET) det_demand[idx] = value;
					CMD_CNT:   if (idx < N_CNT) cnt_value[idx] = value;
					CMD_OP:    pool[idx] = {s_tdata[43:40], s_tdata[51:44], s_tdata[59:52]};
					CMD_RULE:  if (idx < N_RULE) rule_base[idx] = s_tdata[67:60];
					CMD_TRANS: if (idx < N_TRANS) begin
						tr_from[idx] = s_tdata[75:68];
						tr_prio[idx] = s_tdata[83:76];
						tr_rule[idx] = s_tdata[88:84];
					end
					CMD_EVAL: begin
						want = '0;
						want.rule_true = rule_holds(idx);
						verdict_q.push_back(want);
					end
					default: verdict_q.push_back(pick_transition(s_tdata[96:89]));
				endcase
			end
		end
		pending = verdict_q.size();
	end

endmodule

// ===== bench/tb.sv =====
// Stimulus and verdict for the rule bytecode transition select block.
module tb;
	import rbts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cmd_t        cmd;
		logic [7:0]  idx;
		logic [31:0] value;
		logic [3:0]  opc;
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  base;
		logic [7:0]  from_st;
		logic [7:0]  prio;
		logic [4:0]  rule;
		logic [7:0]  cur;
	} request_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// index, value, op_code, operand_a, operand_b, rule_start, from_state,
	// priority_req, rule_index, current_state from bit 0 up, zero fill above.
	logic [103:0] s_tdata = '0;
	// cmd
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// rule_true, found, best_index, best_priority, best_rule, best_from from bit 0 up.
	logic [31:0]  m_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int           mismatches;
	int           pending;
	int           results;

	// Test-side view of the state that steers the random requests.
	int           sent = 0;
	bit           quiet = 0;
	int           hold_left = 0;
	int           run_left = 0;
	int           stall_left = 0;
	logic [7:0]   any_code = 8'd255;

	rule_bytecode_transition_select_core dut (.*);
	rbts_checker chk (.*);

	always #5 clk = ~clk;

	// Give up well past the slowest correct run.
	initial begin
		#60ms;
		$display("Mismatches found");
		$finish;
	end

	// Gap length: mostly zero or short, now and then a long one.
	function automatic int gap_draw();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// Result side. A long hold, when requested, keeps tready low for a fixed
	// count so that the block fills up and has to push back on the request side.
	always @(posedge clk) begin
		int r;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 3) run_left = 200;
			else if (r >= 65) stall_left = gap_draw();
			m_tready <= (r < 65);
		end
	end

	// Offer one request and return at the edge where it is taken.
	task automatic push(request_t r);
		int gap;
		gap = quiet ? 0 : gap_draw();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.cmd;
		s_tdata <= {7'd0, r.cur, r.rule, r.prio, r.from_st, r.base, r.b, r.a, r.opc,
			r.value, r.idx};
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// A request with all fields but command, index and value random, so that unused fields toggle too.
	function automatic request_t mk(cmd_t c, logic [7:0] i, logic [31:0] v = 0);
		request_t r;
		r.cmd = c;
		r.idx = i;
		r.value = v;
		r.opc = 4'($urandom);
		r.a = 8'($urandom);
		r.b = 8'($urandom);
		r.base = 8'($urandom);
		r.from_st = 8'($urandom);
		r.prio = 8'($urandom);
		r.rule = 5'($urandom);
		r.cur = 8'($urandom);
		return r;
	endfunction

	task automatic put_op(logic [7:0] i, logic [3:0] opc, logic [7:0] a, logic [7:0] b);
		request_t r;
		r = mk(CMD_OP, i);
		r.opc = opc;
		r.a = a;
		r.b = b;
		push(r);
	endtask

	task automatic put_rule(logic [7:0] i, logic [7:0] base);
		request_t r;
		r = mk(CMD_RULE, i);
		r.base = base;
		push(r);
	endtask

	task automatic put_trans(logic [7:0] i);
		request_t r;
		r = mk(CMD_TRANS, i);
		r.from_st = ($urandom_range(0, 2) == 0) ? any_code : 8'($urandom_range(0, 7));
		push(r);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom_range(0, 20);
			default: return $urandom;
		endcase
	endfunction

	// Operand codes spread over phase, detector, counter, node and literal ranges.
	function automatic logic [7:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(0, 31));
			1: return 8'($urandom_range(CODE_DET, CODE_CNT - 1));
			2: return 8'($urandom_range(CODE_CNT, CODE_CNT_END - 1));
			3: return 8'($urandom_range(CODE_CNT_END, CODE_LIT - 1));
			default: return 8'($urandom_range(CODE_LIT, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_index(int top);
		return ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, top));
	endfunction

	task automatic random_request();
		request_t r;
		int w;
		w = $urandom_range(0, 99);
		if (w < 8) r = mk(CMD_PHASE, rand_index(31), rand_word());
		else if (w < 16) r = mk(CMD_DET, rand_index(31), rand_word());
		else if (w < 24) r = mk(CMD_CNT, rand_index(11), rand_word());
		else if (w < 48) begin
			r = mk(CMD_OP, 8'($urandom));
			w = $urandom_range(0, 99);
			// Frequent none operators keep rule bodies short.
			r.opc = (w < 22) ? OP_NONE : (w < 27) ? 4'($urandom_range(14, 15)) :
				4'($urandom_range(OP_EQ, OP_OR));
			r.a = rand_operand();
			r.b = rand_operand();
		end else if (w < 56) r = mk(CMD_RULE, rand_index(31));
		else if (w < 62) begin
			r = mk(CMD_TRANS, rand_index(31));
			r.from_st = ($urandom_range(0, 2) == 0) ? any_code : 8'($urandom_range(0, 7));
		end else if (w < 82) r = mk(CMD_EVAL, rand_index(31));
		else begin
			r = mk(CMD_SEL, 8'($urandom));
			if ($urandom_range(0, 4) != 0) r.cur = 8'($urandom_range(0, 7));
		end
		push(r);
	endtask

	// A long chain of operations so that node references past the first
	// operand ranges become live, followed by one entry that reads them.
	task automatic node_chain();
		int i;
		for (i = 0; i < 90; i++)
			put_op(8'(i), 4'($urandom_range(OP_EQ, OP_OR)), rand_operand(),
				8'($urandom_range(CODE_LIT, 255)));
		put_op(8'd90, OP_ADD, 8'($urandom_range(CODE_CNT_END, 89)),
			8'($urandom_range(CODE_CNT_END, CODE_LIT - 1)));
		put_op(8'd91, OP_NONE, 8'd0, 8'd0);
		put_rule(8'd7, 8'd0);
		push(mk(CMD_EVAL, 8'd7));
		push(mk(CMD_SEL, 8'd0));
	endtask

	// Registers change only while nothing is in flight.
	task automatic set_config(int unsigned lim, int unsigned use_n, logic [7:0] any);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {REG_OP_LIMIT, 2'b00}; pwdata <= lim;
		@(posedge clk) penable <= 1'b1;
		@(posedge clk) penable <= 1'b0;
		paddr <= {REG_TRANS_USE, 2'b00}; pwdata <= use_n;
		@(posedge clk) penable <= 1'b1;
		@(posedge clk) penable <= 1'b0;
		paddr <= {REG_ANY_STATE, 2'b00}; pwdata <= {24'd0, any};
		@(posedge clk) penable <= 1'b1;
		@(posedge clk) begin
			psel <= 1'b0;
			penable <= 1'b0;
		end
		any_code = any;
		@(posedge clk);
	endtask

	initial begin
		int p, k;
		int unsigned lim, use_n;
		logic [7:0] any;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the whole transition table first; select never reads an unwritten entry.
		for (k = 0; k < 32; k++) put_trans(8'(k));

		// Directed part: field extremes, ignored writes and the special results.
		push(mk(CMD_PHASE, 8'd0, 32'hFFFF_FFFF));
		push(mk(CMD_DET, 8'd31, 32'd0));
		push(mk(CMD_CNT, 8'd11, 32'd7));
		push(mk(CMD_PHASE, 8'd200, 32'd5));
		push(mk(CMD_CNT, 8'd12, 32'd9));
		put_rule(8'd40, 8'd3);
		push(mk(CMD_TRANS, 8'd32));
		// Subtraction saturates at zero.
		put_op(8'd250, OP_SUB, 8'd131, 8'd137);
		put_rule(8'd1, 8'd250);
		push(mk(CMD_EVAL, 8'd1));
		// Divide and modulo by a zero detector demand.
		put_op(8'd252, OP_DIV, 8'd0, 8'd63);
		put_op(8'd253, OP_MOD, 8'd135, 8'd63);
		put_rule(8'd2, 8'd252);
		push(mk(CMD_EVAL, 8'd2));
		// Addition wraps, and the walk stops at the end of the pool.
		put_op(8'd255, OP_ADD, 8'd0, 8'd129);
		put_rule(8'd3, 8'd255);
		push(mk(CMD_EVAL, 8'd3));
		put_op(8'd10, OP_OR, 8'd0, 8'd128);
		put_rule(8'd5, 8'd10);
		push(mk(CMD_EVAL, 8'd5));
		// Out-of-range rule, an empty rule, and select with nothing to scan.
		push(mk(CMD_EVAL, 8'd40));
		push(mk(CMD_EVAL, 8'd0));
		push(mk(CMD_SEL, 8'd3));

		for (p = 0; p < 12; p++) begin
			case (p)
				0: begin lim = 256; use_n = 32; any = 8'd255; end
				1: begin lim = 0; use_n = 32; any = 8'd0; end
				2: begin lim = 1; use_n = 5; any = 8'd3; end
				3: begin lim = 256; use_n = 32; any = 8'd255; end
				default: begin
					k = $urandom_range(0, 3);
					lim = (k < 2) ? $urandom_range(2, 12) : (k == 2) ? 256 : $urandom_range(0, 256);
					use_n = $urandom_range(0, 32);
					any = ($urandom_range(0, 2) == 0) ? 8'd255 : 8'($urandom_range(0, 7));
				end
			endcase
			set_config(lim, use_n, any);
			quiet = (p % 4 == 3);
			if (p == 3) node_chain();
			if (p == 5) begin
				// Long receiver hold while evaluations keep arriving.
				hold_left = 600;
				for (k = 0; k < 12; k++) push(mk(CMD_EVAL, 8'($urandom_range(0, 31))));
			end
			for (k = 0; k < 150; k++) random_request();
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d requests over 12 register settings; checked %0d results.",
			sent, results);
		$display("Covered all operators, saturation, zero divisors, node references and selects.");
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/rbts_pkg.sv
hw/rtl/rbts_ram.sv
hw/rtl/rbts_div.sv
hw/rtl/rbts_dp.sv
hw/rtl/rbts_ctrl.sv
hw/rtl/rule_bytecode_transition_select_core.sv
hw/rtl/rbts_checker.sv
bench/rbts_checker.sv
bench/tb.sv
